// ===== hw/rtl/gzhp_pkg.sv =====
// Package for the gzip header parser: phase and status codes, header byte constants.
// No dependencies; used by gzip_header_parser and gzhp_checker.
package gzhp_pkg;

  localparam int unsigned PhaseW  = 4;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FlagsW  = 5;
  localparam int unsigned SkipW   = 16;

  localparam logic [7:0] Magic0Byte   = 8'h1f;
  localparam logic [7:0] Magic1Byte   = 8'h8b;
  localparam logic [7:0] DeflateByte  = 8'h08;
  localparam logic [7:0] ReservedMask = 8'hE0;

  localparam int unsigned FlagText    = 0;
  localparam int unsigned FlagHcrc    = 1;
  localparam int unsigned FlagExtra   = 2;
  localparam int unsigned FlagName    = 3;
  localparam int unsigned FlagComment = 4;

  localparam logic [SkipW-1:0] Skip6Len = 16'd6;
  localparam logic [SkipW-1:0] HcrcLen  = 16'd2;

  typedef enum logic [PhaseW-1:0] {
    PhMagic0  = 4'd0,
    PhMagic1  = 4'd1,
    PhMethod  = 4'd2,
    PhFlags   = 4'd3,
    PhSkip6   = 4'd4,
    PhXlen0   = 4'd5,
    PhXlen1   = 4'd6,
    PhExtra   = 4'd7,
    PhName    = 4'd8,
    PhComment = 4'd9,
    PhHcrc    = 4'd10,
    PhIdle    = 4'd11
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    StOk      = 2'd0,
    StDataErr = 2'd1,
    StEmpty   = 2'd2,
    StTrunc   = 2'd3
  } status_e;

endpackage

// ===== hw/rtl/gzip_header_parser.sv =====
// gzip member header parser: one stream byte per request, one status per header.
// Depends on gzhp_pkg.

// Takes one byte request per cycle and checks a gzip member header: magic
// bytes, deflate method, clear reserved flags, then walks over the fixed six
// bytes, optional extra field, name, comment and header CRC (not checked).
// Exactly one status request comes out when the header ends or fails
// (ok, data error, empty stream, truncated); after it bytes are dropped until
// a request with first_byte_i set. Each byte is handled by the phase logic
// ahead of a single output register, so a new byte is taken every
// cycle; in_ready_o only drops while a status waits in that register and
// out_ready_i is low. Status appears the cycle after the byte that causes it.
module gzip_header_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           end_of_input_i,
  input  logic                           first_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [gzhp_pkg::StatusW-1:0]   status_o,
  output logic [gzhp_pkg::FlagsW-1:0]    header_flags_o
);

  gzhp_pkg::phase_e                phase_q, phase_d;
  logic [gzhp_pkg::SkipW-1:0]      skip_q, skip_d;
  logic [gzhp_pkg::FlagsW-1:0]     flags_q, flags_d;
  logic                            out_valid_q;
  gzhp_pkg::status_e               status_q, status_d;
  logic [gzhp_pkg::FlagsW-1:0]     oflags_q;
  logic                            emit;
  logic                            accept;
  gzhp_pkg::phase_e                ph;
  logic [gzhp_pkg::SkipW-1:0]      skip;
  logic [gzhp_pkg::FlagsW-1:0]     fl;
  logic [gzhp_pkg::SkipW-1:0]      skip_dec;

  // next optional section after the one finished
  function automatic gzhp_pkg::phase_e next_sec(gzhp_pkg::phase_e done,
                                                logic [gzhp_pkg::FlagsW-1:0] f);
    gzhp_pkg::phase_e r;
    r = gzhp_pkg::PhIdle;
    if (done < gzhp_pkg::PhXlen0 && f[gzhp_pkg::FlagExtra]) begin
      r = gzhp_pkg::PhXlen0;
    end else if (done < gzhp_pkg::PhName && f[gzhp_pkg::FlagName]) begin
      r = gzhp_pkg::PhName;
    end else if (done < gzhp_pkg::PhComment && f[gzhp_pkg::FlagComment]) begin
      r = gzhp_pkg::PhComment;
    end else if (done < gzhp_pkg::PhHcrc && f[gzhp_pkg::FlagHcrc]) begin
      r = gzhp_pkg::PhHcrc;
    end
    return r;
  endfunction

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  assign ph       = first_byte_i ? gzhp_pkg::PhMagic0 : phase_q;
  assign skip     = first_byte_i ? '0 : skip_q;
  assign fl       = first_byte_i ? '0 : flags_q;
  assign skip_dec = skip - 1'b1;

  always_comb begin
    phase_d  = ph;
    skip_d   = skip;
    flags_d  = fl;
    emit     = 1'b0;
    status_d = gzhp_pkg::StOk;
    if (ph >= gzhp_pkg::PhIdle) begin
      phase_d = ph;
    end else if (end_of_input_i) begin
      emit     = 1'b1;
      status_d = (ph == gzhp_pkg::PhMagic0) ? gzhp_pkg::StEmpty : gzhp_pkg::StTrunc;
      phase_d  = gzhp_pkg::PhIdle;
    end else begin
      case (ph)
        gzhp_pkg::PhMagic0: begin
          if (data_byte_i != gzhp_pkg::Magic0Byte) begin
            emit     = 1'b1;
            status_d = gzhp_pkg::StDataErr;
            phase_d  = gzhp_pkg::PhIdle;
          end else begin
            phase_d = gzhp_pkg::PhMagic1;
          end
        end
        gzhp_pkg::PhMagic1: begin
          if (data_byte_i != gzhp_pkg::Magic1Byte) begin
            emit     = 1'b1;
            status_d = gzhp_pkg::StDataErr;
            phase_d  = gzhp_pkg::PhIdle;
          end else begin
            phase_d = gzhp_pkg::PhMethod;
          end
        end
        gzhp_pkg::PhMethod: begin
          // nonzero count marks a bad method
          skip_d  = (data_byte_i != gzhp_pkg::DeflateByte) ? 16'd1 : 16'd0;
          phase_d = gzhp_pkg::PhFlags;
        end
        gzhp_pkg::PhFlags: begin
          flags_d = data_byte_i[gzhp_pkg::FlagsW-1:0];
          if (skip != '0 || (data_byte_i & gzhp_pkg::ReservedMask) != 8'h00) begin
            emit     = 1'b1;
            status_d = gzhp_pkg::StDataErr;
            phase_d  = gzhp_pkg::PhIdle;
          end else begin
            skip_d  = gzhp_pkg::Skip6Len;
            phase_d = gzhp_pkg::PhSkip6;
          end
        end
        gzhp_pkg::PhSkip6, gzhp_pkg::PhExtra, gzhp_pkg::PhHcrc: begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            phase_d = next_sec(ph, fl);
          end
        end
        gzhp_pkg::PhXlen0: begin
          skip_d  = {8'h00, data_byte_i};
          phase_d = gzhp_pkg::PhXlen1;
        end
        gzhp_pkg::PhXlen1: begin
          skip_d = {data_byte_i, skip[7:0]};
          if ({data_byte_i, skip[7:0]} == '0) begin
            phase_d = next_sec(gzhp_pkg::PhExtra, fl);
          end else begin
            phase_d = gzhp_pkg::PhExtra;
          end
        end
        gzhp_pkg::PhName, gzhp_pkg::PhComment: begin
          if (data_byte_i == 8'h00) begin
            phase_d = next_sec(ph, fl);
          end
        end
        default: begin
          phase_d = ph;
        end
      endcase
      // section walk finished: header ok
      if (!emit && phase_d == gzhp_pkg::PhIdle) begin
        emit     = 1'b1;
        status_d = gzhp_pkg::StOk;
      end
      if (phase_d == gzhp_pkg::PhHcrc && ph != gzhp_pkg::PhHcrc) begin
        skip_d = gzhp_pkg::HcrcLen;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= gzhp_pkg::PhMagic0;
      skip_q      <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        skip_q  <= skip_d;
        flags_q <= flags_d;
      end
      if (accept && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      status_q <= status_d;
      oflags_q <= flags_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign header_flags_o = oflags_q;

endmodule

// ===== hw/rtl/gzhp_checker.sv =====
// Port-level checks for gzip_header_parser, attached by bind.
// Depends on gzhp_pkg.
module gzhp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [7:0]                   data_byte_i,
  input logic                         end_of_input_i,
  input logic                         first_byte_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [gzhp_pkg::StatusW-1:0] status_o,
  input logic [gzhp_pkg::FlagsW-1:0]  header_flags_o
);

  logic in_acc;
  assign in_acc = in_valid_i & in_ready_o;

  // input stalls only behind a waiting status
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("in_ready_o low without a blocked status");

  // stalled status holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(status_o) && $stable(header_flags_o)))
    else $error("stalled status changed");

  // end of input on the first request reports an empty stream
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && first_byte_i && end_of_input_i) |=>
      (out_valid_o && status_o == gzhp_pkg::StEmpty && header_flags_o == '0))
    else $error("empty stream not reported");

  // wrong first magic byte is a data error at once
  a_magic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && first_byte_i && !end_of_input_i && data_byte_i != gzhp_pkg::Magic0Byte)
      |=> (out_valid_o && status_o == gzhp_pkg::StDataErr))
    else $error("bad magic not reported");

endmodule

bind gzip_header_parser gzhp_checker u_gzhp_checker (.*);
